/* rtl/mt64_pkg.sv */
// Package with the constants and types shared by the MT19937-64 generator files.
`default_nettype none

package mt64_pkg;

    localparam int STATE_DEPTH   = 312;
    localparam int MIDDLE_OFFSET = 156;
    localparam int WORD_W        = 64;
    localparam int ADDR_W        = $clog2(STATE_DEPTH);

    localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] HIGH_MASK    = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] LOW_MASK     = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] SEED_MULT    = 64'd6364136223846793005;
    localparam logic [63:0] DEFAULT_SEED = 64'd5489;

    localparam logic [63:0] TEMPER_MASK_A = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TEMPER_MASK_B = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] TEMPER_MASK_C = 64'hFFF7_EEE0_0000_0000;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD0,
        S_SEED,
        S_TWIST
    } t_state;

    // Which partial product of the 64-bit seed multiplication is being formed.
    typedef enum logic [1:0] {
        PH_LO_LO,
        PH_HI_LO,
        PH_LO_HI
    } t_mul_phase;

    // Output tempering of one state word.
    function automatic logic [63:0] temper(input logic [63:0] x);
        logic [63:0] t;
        t = x;
        t = t ^ ((t >> 29) & TEMPER_MASK_A);
        t = t ^ ((t << 17) & TEMPER_MASK_B);
        t = t ^ ((t << 37) & TEMPER_MASK_C);
        t = t ^ (t >> 43);
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/mt64_ram.sv */
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module mt64_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 312,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    output logic      [WIDTH-1:0] o_rdata_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

/* rtl/mersenne_twister_64_generator.sv */
// Top level of the MT19937-64 pseudo-random generator with its state memory.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_reseed (1 bit)
//  out     | output    | o_out_valid / i_out_ready | o_random_word (64 bits)
//  config  | input     | i_seed_we (no wait)       | i_seed (64 bits)
//
// A draw first reads the state memory, then twists the word, writes it back
// and registers the tempered result; no new request is taken until it is
// done. Its pace is set by the read latency of the state memory.
// A reseed fills the 312 words, each after the first from three partial products,
// because the 64-bit seed multiply runs on one shared 32x32 multiplier.
// After reset the same fill runs with seed 5489 and no input is taken until
// it is done. A stalled output holds the twist stage until the result leaves.
`default_nettype none

module mersenne_twister_64_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_reseed,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [63:0] o_random_word,
    input  wire logic        i_seed_we,
    input  wire logic [63:0] i_seed
);

    import mt64_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] MID_ADDR  = ADDR_W'(MIDDLE_OFFSET);

    // Control state.
    t_state            r_state, n_state;
    t_mul_phase        r_phase, n_phase;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_k, n_k;
    logic              r_draw, n_draw;
    logic              r_out_valid, n_out_valid;

    // Data registers.
    logic [63:0] r_seed;
    logic [63:0] r_prev, n_prev;
    logic [63:0] r_cache, n_cache;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_word, n_word;

    // Memory ports.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [63:0]       mem_wdata;
    logic [ADDR_W-1:0] addr_next;
    logic [ADDR_W-1:0] addr_mid;
    logic [63:0]       rd_next;
    logic [63:0]       rd_mid;

    // Seed recurrence datapath.
    logic [63:0] seed_t;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] seed_word;

    // Twist datapath.
    logic [63:0] tw_x;
    logic [63:0] tw_y;
    logic [63:0] tw_word;
    logic        out_free;
    logic        in_xfer;

    // The state memory holds the 312 words. Read port A always fetches the
    // word after the pointer, port B the word half a vector ahead.
    mt64_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (addr_next),
        .o_rdata_a (rd_next),
        .i_raddr_b (addr_mid),
        .o_rdata_b (rd_mid)
    );

    assign addr_next = (r_ptr == LAST_ADDR) ? '0 : r_ptr + 1'b1;
    assign addr_mid  = (r_ptr >= MID_ADDR) ? r_ptr - MID_ADDR : r_ptr + MID_ADDR;

    // The word is twisted lazily, one per draw, in place. Going in ascending
    // order, the next word is still from the old generation (except at the
    // wrap, where word 0 is already new, as the recurrence wants) and the
    // middle word is old in the first half and new in the second half.
    // The current word is never read: it was fetched as the next word by the
    // previous draw and kept in r_cache.
    assign tw_x    = (r_cache & HIGH_MASK) | (rd_next & LOW_MASK);
    assign tw_y    = (tw_x >> 1) ^ (tw_x[0] ? TWIST_MATRIX : 64'd0);
    assign tw_word = rd_mid ^ tw_y;

    // The seed product keeps only its low 64 bits, so it is the low-by-low
    // product plus the two cross products shifted up by 32.
    assign seed_t = r_prev ^ (r_prev >> 62);
    always_comb begin
        case (r_phase)
            PH_LO_LO: begin
                mul_a = seed_t[31:0];
                mul_b = SEED_MULT[31:0];
            end
            PH_HI_LO: begin
                mul_a = seed_t[63:32];
                mul_b = SEED_MULT[31:0];
            end
            default: begin
                mul_a = seed_t[31:0];
                mul_b = SEED_MULT[63:32];
            end
        endcase
    end
    assign mul_p     = 64'(mul_a) * 64'(mul_b);
    assign seed_word = r_acc + {mul_p[31:0], 32'd0} + 64'(r_k);

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_ptr       = r_ptr;
        n_k         = r_k;
        n_draw      = r_draw;
        n_prev      = r_prev;
        n_cache     = r_cache;
        n_acc       = r_acc;
        n_word      = r_word;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_waddr   = r_ptr;
        mem_wdata   = tw_word;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_reseed) begin
                        n_prev  = r_seed;
                        n_draw  = 1'b1;
                        n_state = S_LOAD0;
                    end else begin
                        n_state = S_TWIST;
                    end
                end
            end
            S_LOAD0: begin
                // Word 0 is the seed itself; it is also the current word.
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_prev;
                n_cache   = r_prev;
                n_ptr     = '0;
                n_k       = ADDR_W'(1);
                n_phase   = PH_LO_LO;
                n_state   = S_SEED;
            end
            S_SEED: begin
                unique case (r_phase)
                    PH_LO_LO: begin
                        n_acc   = mul_p;
                        n_phase = PH_HI_LO;
                    end
                    PH_HI_LO: begin
                        n_acc   = r_acc + {mul_p[31:0], 32'd0};
                        n_phase = PH_LO_HI;
                    end
                    default: begin
                        mem_we    = 1'b1;
                        mem_waddr = r_k;
                        mem_wdata = seed_word;
                        n_prev    = seed_word;
                        n_phase   = PH_LO_LO;
                        n_k       = r_k + 1'b1;
                        if (r_k == LAST_ADDR) begin
                            n_draw  = 1'b0;
                            n_state = r_draw ? S_TWIST : S_IDLE;
                        end
                    end
                endcase
            end
            S_TWIST: begin
                if (out_free) begin
                    mem_we      = 1'b1;
                    n_word      = temper(tw_word);
                    n_out_valid = 1'b1;
                    n_cache     = rd_next;
                    n_ptr       = addr_next;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD0;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers. Reset starts the fill from the default seed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LO_LO;
            r_ptr       <= '0;
            r_k         <= ADDR_W'(1);
            r_draw      <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= DEFAULT_SEED;
            r_seed      <= DEFAULT_SEED;
        end else begin
            r_phase     <= n_phase;
            r_ptr       <= n_ptr;
            r_k         <= n_k;
            r_draw      <= n_draw;
            r_out_valid <= n_out_valid;
            r_prev      <= n_prev;
            if (i_seed_we) begin
                r_seed <= i_seed;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cache <= n_cache;
        r_acc   <= n_acc;
        r_word  <= n_word;
    end

    assign o_out_valid   = r_out_valid;
    assign o_random_word = r_word;

    // The draw pointer never leaves the state vector.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= LAST_ADDR)
        else $error("draw pointer out of range");

    // A reseed transfer always starts the fill with word 0.
    a_reseed_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_reseed) |=> (r_state == S_LOAD0) && r_draw)
        else $error("reseed did not start the fill");

    // A new result only appears after a twist step.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_TWIST))
        else $error("result appeared without a twist");

    // A pending result is never overwritten while the output is stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_word) && r_out_valid)
        else $error("stalled result was overwritten");

    // The fill counter stays within words 1 to 311 while seeding.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEED) |-> (r_k != '0) && (r_k <= LAST_ADDR))
        else $error("fill counter out of range");

endmodule

`default_nettype wire
